@@ rtl/core/ptpe_pkg.sv @@
// shared types and constants of the particle trail point emitter
// used by ptpe_alu, ptpe_clip and particle_trail_point_emitter
package ptpe_pkg;

    localparam int FRAC_BITS    = 10;
    localparam int MAX_TAIL     = 15;
    localparam int GRAVITY_STEP = 1024;

    // working widths: position walk, projection sum, pixel coordinates
    localparam int POS_W = 32;
    localparam int VEL_W = 24;
    localparam int ALU_W = 34;
    localparam int PIX_W = 26;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] CFG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] CFG_CLIP_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_CLIP_BOTTOM = 2'd3;

    // blob candidate order: below, right, left, above
    localparam logic [1:0] CAND_BELOW = 2'd0;
    localparam logic [1:0] CAND_RIGHT = 2'd1;
    localparam logic [1:0] CAND_LEFT  = 2'd2;
    localparam logic [1:0] CAND_ABOVE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIPLE,
        S_ROUND,
        S_ROW,
        S_EMIT,
        S_STEP_X,
        S_STEP_Y,
        S_STEP_Z,
        S_STEP_W
    } t_state;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } t_clip;

    typedef struct packed {
        logic [15:0] rel_x;
        logic [15:0] rel_y;
        logic        visible;
    } t_point;

endpackage

@@ rtl/core/ptpe_alu.sv @@
// shared add/subtract unit of the trail walk and projection
// depends on ptpe_pkg
module ptpe_alu
    import ptpe_pkg::*;
(
    input  logic signed [ALU_W-1:0] i_a,
    input  logic signed [ALU_W-1:0] i_b,
    input  logic                    i_sub,
    output logic signed [ALU_W-1:0] o_sum
);

    assign o_sum = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

@@ rtl/core/ptpe_clip.sv @@
// candidate offset and half-open clip rectangle test for one point
// depends on ptpe_pkg
module ptpe_clip
    import ptpe_pkg::*;
(
    input  logic signed [PIX_W-1:0] i_col,
    input  logic signed [PIX_W-1:0] i_row,
    input  logic                    i_blob,
    input  logic [1:0]              i_cand,
    input  t_clip                   i_clip,
    output t_point                  o_point
);

    logic signed [PIX_W-1:0] w_px;
    logic signed [PIX_W-1:0] w_py;
    logic signed [PIX_W-1:0] w_l;
    logic signed [PIX_W-1:0] w_t;
    logic signed [PIX_W-1:0] w_r;
    logic signed [PIX_W-1:0] w_b;
    logic signed [PIX_W-1:0] w_dx;
    logic signed [PIX_W-1:0] w_dy;
    logic signed [PIX_W-1:0] w_ox;
    logic signed [PIX_W-1:0] w_oy;
    logic                    w_vis;

    always_comb begin
        w_ox = '0;
        w_oy = '0;
        if (i_blob) begin
            case (i_cand)
                CAND_BELOW: w_oy = PIX_W'(1);
                CAND_RIGHT: w_ox = PIX_W'(1);
                CAND_LEFT:  w_ox = -PIX_W'(1);
                default:    w_oy = -PIX_W'(1);
            endcase
        end
    end

    assign w_px = i_col + w_ox;
    assign w_py = i_row + w_oy;
    assign w_l  = {{(PIX_W-16){i_clip.left[15]}}, i_clip.left};
    assign w_t  = {{(PIX_W-16){i_clip.top[15]}}, i_clip.top};
    assign w_r  = {{(PIX_W-16){i_clip.right[15]}}, i_clip.right};
    assign w_b  = {{(PIX_W-16){i_clip.bottom[15]}}, i_clip.bottom};
    assign w_dx = w_px - w_l;
    assign w_dy = w_py - w_t;

    assign w_vis = (w_px >= w_l) && (w_px < w_r) && (w_py >= w_t) && (w_py < w_b);

    assign o_point.visible = w_vis;
    assign o_point.rel_x   = w_vis ? w_dx[15:0] : 16'd0;
    assign o_point.rel_y   = w_vis ? w_dy[15:0] : 16'd0;

endmodule

@@ rtl/core/particle_trail_point_emitter.sv @@
// top level: request sequencer, walk registers, clip registers, output register
// depends on ptpe_pkg, ptpe_alu, ptpe_clip
//
// One particle request yields min(tail_length, age_ticks)+1 trail points, each giving
// one result in dot mode or four in blob mode, up to 64 results. A single shared
// add/subtract unit does all arithmetic: per trail point the states S_TRIPLE, S_ROUND
// and S_ROW project the row, S_EMIT loads the output register once per candidate and
// holds while the output register is full and stalled, and S_STEP_X, S_STEP_Y,
// S_STEP_Z and S_STEP_W step x, y, z and the vertical velocity after every point but
// the last. The input is ready only while no request is in work; a finished result
// may still wait in the output register. Configuration writes are taken at any edge
// with the write enable high.
module particle_trail_point_emitter
    import ptpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    // particle request
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_x[29:0] pos_y[59:30] pos_z[89:60] vel_x[110:90] vel_y[131:111]
    // vel_z[152:132] tail_length[156:153] age_ticks[172:157] zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,   // mode
    // candidate points
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // rel_x[15:0] rel_y[31:16]
    output logic                  o_m_tuser,   // visible
    output logic                  o_m_tlast    // last
);

    t_state r_state, n_state;
    t_clip  r_clip;

    logic signed [POS_W-1:0] r_x, n_x;
    logic signed [POS_W-1:0] r_y, n_y;
    logic signed [POS_W-1:0] r_z, n_z;
    logic signed [VEL_W-1:0] r_w, n_w;
    logic signed [VEL_W-1:0] r_vx, n_vx;
    logic signed [VEL_W-1:0] r_vy, n_vy;
    logic signed [ALU_W-1:0] r_tmp, n_tmp;
    logic                    r_blob, n_blob;
    logic [3:0]              r_pts_left, n_pts_left;
    logic [1:0]              r_cand, n_cand;

    logic                    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic                    r_out_vis, n_out_vis;
    logic                    r_out_last, n_out_last;

    logic signed [ALU_W-1:0] w_a;
    logic signed [ALU_W-1:0] w_b;
    logic                    w_sub;
    logic signed [ALU_W-1:0] w_sum;
    logic signed [PIX_W-1:0] w_col;
    logic signed [PIX_W-1:0] w_row;
    t_point                  w_point;
    logic [3:0]              w_tail;
    logic [15:0]             w_age;
    logic [3:0]              w_cnt;
    logic                    w_out_free;
    logic                    w_last_cand;

    ptpe_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_sum (w_sum)
    );

    // floor shift of position and projected row
    assign w_col = {{(PIX_W-(POS_W-FRAC_BITS)){r_x[POS_W-1]}}, r_x[POS_W-1:FRAC_BITS]};
    assign w_row = {{(PIX_W-(ALU_W-FRAC_BITS)){r_tmp[ALU_W-1]}}, r_tmp[ALU_W-1:FRAC_BITS]};

    ptpe_clip u_clip (
        .i_col   (w_col),
        .i_row   (w_row),
        .i_blob  (r_blob),
        .i_cand  (r_cand),
        .i_clip  (r_clip),
        .o_point (w_point)
    );

    assign w_tail      = i_s_tdata[156:153];
    assign w_age       = i_s_tdata[172:157];
    assign w_cnt       = (w_age < {12'd0, w_tail}) ? w_age[3:0] : w_tail;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_last_cand = r_blob ? (r_cand == CAND_ABOVE) : 1'b1;

    // shared unit operand selection
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        unique case (r_state)
            S_TRIPLE: begin
                w_a = {{(ALU_W-POS_W){r_y[POS_W-1]}}, r_y};
                w_b = {{(ALU_W-POS_W-1){r_y[POS_W-1]}}, r_y, 1'b0};
            end
            S_ROUND: begin
                // bias negative values so the shift truncates toward zero
                w_a = r_tmp;
                w_b = r_tmp[ALU_W-1] ? ALU_W'(3) : '0;
            end
            S_ROW: begin
                w_a   = {{2{r_tmp[ALU_W-1]}}, r_tmp[ALU_W-1:2]};
                w_b   = {{(ALU_W-POS_W){r_z[POS_W-1]}}, r_z};
                w_sub = 1'b1;
            end
            S_STEP_X: begin
                w_a   = {{(ALU_W-POS_W){r_x[POS_W-1]}}, r_x};
                w_b   = {{(ALU_W-VEL_W){r_vx[VEL_W-1]}}, r_vx};
                w_sub = 1'b1;
            end
            S_STEP_Y: begin
                w_a   = {{(ALU_W-POS_W){r_y[POS_W-1]}}, r_y};
                w_b   = {{(ALU_W-VEL_W){r_vy[VEL_W-1]}}, r_vy};
                w_sub = 1'b1;
            end
            S_STEP_Z: begin
                w_a   = {{(ALU_W-POS_W){r_z[POS_W-1]}}, r_z};
                w_b   = {{(ALU_W-VEL_W){r_w[VEL_W-1]}}, r_w};
                w_sub = 1'b1;
            end
            S_STEP_W: begin
                w_a = {{(ALU_W-VEL_W){r_w[VEL_W-1]}}, r_w};
                w_b = ALU_W'(GRAVITY_STEP);
            end
            S_IDLE, S_EMIT: begin
                w_a = '0;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_w         = r_w;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_tmp       = r_tmp;
        n_blob      = r_blob;
        n_pts_left  = r_pts_left;
        n_cand      = r_cand;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_vis   = r_out_vis;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_blob     = i_s_tuser;
                    n_x        = {{(POS_W-30){i_s_tdata[29]}}, i_s_tdata[29:0]};
                    n_y        = {{(POS_W-30){i_s_tdata[59]}}, i_s_tdata[59:30]};
                    n_z        = {{(POS_W-30){i_s_tdata[89]}}, i_s_tdata[89:60]};
                    n_vx       = {{(VEL_W-21){i_s_tdata[110]}}, i_s_tdata[110:90]};
                    n_vy       = {{(VEL_W-21){i_s_tdata[131]}}, i_s_tdata[131:111]};
                    n_w        = {{(VEL_W-21){i_s_tdata[152]}}, i_s_tdata[152:132]};
                    n_pts_left = w_cnt;
                    n_state    = S_TRIPLE;
                end
            end
            S_TRIPLE: begin
                n_tmp   = w_sum;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_tmp   = w_sum;
                n_state = S_ROW;
            end
            S_ROW: begin
                n_tmp   = w_sum;
                n_cand  = CAND_BELOW;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {w_point.rel_y, w_point.rel_x};
                    n_out_vis   = w_point.visible;
                    n_out_last  = w_last_cand && (r_pts_left == 4'd0);
                    if (!w_last_cand) begin
                        n_cand = r_cand + 2'd1;
                    end else if (r_pts_left == 4'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_STEP_X;
                    end
                end
            end
            S_STEP_X: begin
                n_x     = w_sum[POS_W-1:0];
                n_state = S_STEP_Y;
            end
            S_STEP_Y: begin
                n_y     = w_sum[POS_W-1:0];
                n_state = S_STEP_Z;
            end
            S_STEP_Z: begin
                n_z     = w_sum[POS_W-1:0];
                n_state = S_STEP_W;
            end
            S_STEP_W: begin
                n_w        = w_sum[VEL_W-1:0];
                n_pts_left = r_pts_left - 4'd1;
                n_state    = S_TRIPLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_w        <= n_w;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_tmp      <= n_tmp;
        r_blob     <= n_blob;
        r_pts_left <= n_pts_left;
        r_cand     <= n_cand;
        r_out_data <= n_out_data;
        r_out_vis  <= n_out_vis;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left   <= 16'sd0;
            r_clip.top    <= 16'sd0;
            r_clip.right  <= 16'sd640;
            r_clip.bottom <= 16'sd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLIP_LEFT:   r_clip.left   <= i_cfg_data;
                CFG_CLIP_TOP:    r_clip.top    <= i_cfg_data;
                CFG_CLIP_RIGHT:  r_clip.right  <= i_cfg_data;
                CFG_CLIP_BOTTOM: r_clip.bottom <= i_cfg_data;
                default:         r_clip.left   <= r_clip.left;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_vis;
    assign o_m_tlast  = r_out_last;

    // a point outside the rectangle carries zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("hidden point with nonzero coordinates");

    // an accepted request keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a request");

    // results are loaded only from the emit step
    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(o_m_tvalid) && o_m_tvalid) |-> ($past(r_state) == S_EMIT))
        else $error("result appeared outside the emit step");

endmodule

@@ tb/sv/ptpe_checker.sv @@
// checker for the particle trail point emitter: follows clip register writes, predicts
// the candidate points of every accepted particle request and compares the output stream
// depends on ptpe_pkg
module ptpe_checker
    import ptpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_mismatches,
    output int                    o_points_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [15:0] RESET_RIGHT  = 16'sd640;
    localparam logic signed [15:0] RESET_BOTTOM = 16'sd480;

    typedef struct packed {
        t_point pt;
        logic   last;
    } t_due_point;

    t_due_point points_due[$];
    t_due_point head;
    t_clip      clip;
    int         mismatch_count = 0;

    task automatic report_mismatch(input string what);
        // keep the log short when the design is badly off
        if (mismatch_count < 50)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic t_point clip_point(input longint col, input longint row);
        longint l, t, r, b, dcol, drow;
        t_point p;
        l = $signed(clip.left);
        t = $signed(clip.top);
        r = $signed(clip.right);
        b = $signed(clip.bottom);
        p = '0;
        if (col >= l && col < r && row >= t && row < b) begin
            dcol = col - l;
            drow = row - t;
            p.visible = 1'b1;
            p.rel_x = dcol[15:0];
            p.rel_y = drow[15:0];
        end
        return p;
    endfunction

    // walk the trail back from the head and queue every candidate point
    task automatic expand_trail(input logic blob, input logic [IN_DATA_W-1:0] d);
        longint x, y, z, vx, vy, w, col, row, dx, dy;
        int tail, age, steps, cands, i, k;
        t_due_point due;
        x  = $signed(d[29:0]);
        y  = $signed(d[59:30]);
        z  = $signed(d[89:60]);
        vx = $signed(d[110:90]);
        vy = $signed(d[131:111]);
        w  = $signed(d[152:132]);
        tail = d[156:153];
        age  = d[172:157];
        if (tail > MAX_TAIL)
            tail = MAX_TAIL;
        steps = ((tail < age) ? tail : age) + 1;
        cands = blob ? 4 : 1;
        for (i = 0; i < steps; i++) begin
            col = x >>> FRAC_BITS;
            // depth term truncates toward zero, the final shift floors
            row = ((3 * y) / 4 - z) >>> FRAC_BITS;
            for (k = 0; k < cands; k++) begin
                dx = 0;
                dy = 0;
                if (blob) begin
                    case (k[1:0])
                        CAND_BELOW: dy = 1;
                        CAND_RIGHT: dx = 1;
                        CAND_LEFT:  dx = -1;
                        CAND_ABOVE: dy = -1;
                        default: ;
                    endcase
                end
                due.pt   = clip_point(col + dx, row + dy);
                due.last = (i == steps - 1) && (k == cands - 1);
                points_due.push_back(due);
            end
            x -= vx;
            y -= vy;
            z -= w;
            w += GRAVITY_STEP;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clip.left   = '0;
            clip.top    = '0;
            clip.right  = RESET_RIGHT;
            clip.bottom = RESET_BOTTOM;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expand_trail(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (points_due.size() == 0) begin
                    report_mismatch("candidate point with nothing expected");
                end else begin
                    head = points_due.pop_front();
                    if (i_m_tdata[15:0] !== head.pt.rel_x)
                        report_mismatch($sformatf("rel_x %0d, expected %0d",
                                                  i_m_tdata[15:0], head.pt.rel_x));
                    if (i_m_tdata[31:16] !== head.pt.rel_y)
                        report_mismatch($sformatf("rel_y %0d, expected %0d",
                                                  i_m_tdata[31:16], head.pt.rel_y));
                    if (i_m_tuser !== head.pt.visible)
                        report_mismatch($sformatf("visible %b, expected %b",
                                                  i_m_tuser, head.pt.visible));
                    if (i_m_tlast !== head.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  i_m_tlast, head.last));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLIP_LEFT:   clip.left   = i_cfg_data;
                    CFG_CLIP_TOP:    clip.top    = i_cfg_data;
                    CFG_CLIP_RIGHT:  clip.right  = i_cfg_data;
                    CFG_CLIP_BOTTOM: clip.bottom = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_points_due <= points_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the particle trail point emitter testbench: clock, reset, clip settings,
// particle requests in bursts and a stalling receiver; verdict from ptpe_checker
// depends on ptpe_pkg, ptpe_checker and particle_trail_point_emitter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptpe_pkg::*;

    localparam longint POS_MAX = 536870911;
    localparam longint POS_MIN = -536870912;
    localparam longint VEL_MAX = 1048575;
    localparam longint VEL_MIN = -1048576;

    localparam int READY_FREE   = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SLOW   = 2;
    localparam int READY_HICCUP = 3;

    typedef struct {
        logic        mode;
        logic [29:0] px, py, pz;
        logic [20:0] vx, vy, vz;
        logic [3:0]  tail;
        logic [15:0] age;
    } t_particle;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    mismatches;
    int                    points_due;

    int clip_l, clip_t, clip_r, clip_b;
    int burst_left;
    int ready_cycle = 0;
    int ready_style = READY_FREE;

    particle_trail_point_emitter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    ptpe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_points_due (points_due)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver switches at random between its stall styles
    always @(posedge clk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 300 == 299)
            ready_style <= $urandom_range(READY_FREE, READY_HICCUP);
        case (ready_style)
            READY_FREE: m_tready <= 1'b1;
            READY_COIN: m_tready <= $urandom_range(0, 1);
            READY_SLOW: m_tready <= (ready_cycle % 4 == 0);
            default:    m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic t_particle make_particle(input logic mode, input longint x,
                                                input longint y, input longint z,
                                                input longint vx, input longint vy,
                                                input longint vz, input int tail,
                                                input int age);
        t_particle p;
        p.mode = mode;
        p.px   = x[29:0];
        p.py   = y[29:0];
        p.pz   = z[29:0];
        p.vx   = vx[20:0];
        p.vy   = vy[20:0];
        p.vz   = vz[20:0];
        p.tail = tail[3:0];
        p.age  = age[15:0];
        return p;
    endfunction

    // head at pixel (320, 240) of the default rectangle, drifting and falling
    function automatic t_particle mid_particle(input logic mode, input int tail,
                                               input int age);
        return make_particle(mode, 320 * 1024, 0, -240 * 1024, 3000, 500, -6000, tail, age);
    endfunction

    // trail aimed at the current clip rectangle and just around it
    function automatic t_particle aimed_particle();
        int lo_x, hi_x, lo_y, hi_y, col, row, age;
        longint x, y, z;
        lo_x = (clip_l < clip_r) ? clip_l : clip_r;
        hi_x = (clip_l < clip_r) ? clip_r : clip_l;
        lo_y = (clip_t < clip_b) ? clip_t : clip_b;
        hi_y = (clip_t < clip_b) ? clip_b : clip_t;
        col = lo_x - 3 + $urandom_range(0, hi_x - lo_x + 6);
        row = lo_y - 3 + $urandom_range(0, hi_y - lo_y + 6);
        x = longint'(col) * 1024 + $urandom_range(0, 1023);
        z = longint'($urandom_range(0, 2097152)) - 1048576;
        y = ((longint'(row) * 1024 + 512) + z) * 4 / 3;
        age = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
        return make_particle($urandom_range(0, 1), x, y, z,
                             longint'($urandom_range(0, 8192)) - 4096,
                             longint'($urandom_range(0, 8192)) - 4096,
                             longint'($urandom_range(0, 40000)) - 20000,
                             $urandom_range(0, 15), age);
    endfunction

    function automatic t_particle noise_particle();
        return make_particle($urandom_range(0, 1), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic offer(input t_particle p);
        logic [IN_DATA_W-1:0] d;
        int gap;
        d = '0;
        d[29:0]    = p.px;
        d[59:30]   = p.py;
        d[89:60]   = p.pz;
        d[110:90]  = p.vx;
        d[131:111] = p.vy;
        d[152:132] = p.vz;
        d[156:153] = p.tail;
        d[172:157] = p.age;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= p.mode;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // all requested points delivered and no request in work
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_due != 0 || !s_tready)
            @(posedge clk);
    endtask

    task automatic write_clip(input int l, input int t, input int r, input int b);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLIP_LEFT;
        cfg_data  <= l[15:0];
        @(posedge clk);
        cfg_index <= CFG_CLIP_TOP;
        cfg_data  <= t[15:0];
        @(posedge clk);
        cfg_index <= CFG_CLIP_RIGHT;
        cfg_data  <= r[15:0];
        @(posedge clk);
        cfg_index <= CFG_CLIP_BOTTOM;
        cfg_data  <= b[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        clip_l = $signed(l[15:0]);
        clip_t = $signed(t[15:0]);
        clip_r = $signed(r[15:0]);
        clip_b = $signed(b[15:0]);
        burst_left = $urandom_range(1, 10);
    endtask

    initial begin
        int l, t;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CLIP_LEFT;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        clip_l = 0;
        clip_t = 0;
        clip_r = 640;
        clip_b = 480;
        burst_left = $urandom_range(1, 10);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default rectangle: corners, edges, rounding, field extremes, trail lengths
        offer(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(make_particle(1, 0, 0, 0, 0, 0, 0, 0, 0));
        offer(make_particle(0, 639 * 1024 + 1023, 0, -479 * 1024 - 1023, 0, 0, 0, 0, 0));
        offer(make_particle(1, 639 * 1024, 0, -479 * 1024, 0, 0, 0, 0, 0));
        offer(make_particle(0, -1, -1, 0, 0, 0, 0, 0, 0));
        offer(make_particle(0, 5 * 1024, -5, -1024, 0, 0, 0, 0, 0));
        offer(make_particle(0, POS_MAX, POS_MAX, POS_MAX, VEL_MAX, VEL_MAX, VEL_MAX, 15, 65535));
        offer(make_particle(1, POS_MIN, POS_MIN, POS_MIN, VEL_MIN, VEL_MIN, VEL_MIN, 15, 65535));
        offer(make_particle(1, POS_MAX, POS_MIN, POS_MAX, VEL_MIN, VEL_MAX, VEL_MIN, 15, 65535));
        offer(mid_particle(0, 15, 3));
        offer(mid_particle(1, 2, 65535));
        offer(mid_particle(0, 0, 65535));
        offer(mid_particle(0, 15, 0));
        offer(mid_particle(1, 15, 15));
        offer(mid_particle(0, 7, 6));

        // widest rectangle: offsets reach both ends of their range
        write_clip(-32768, -32768, 32767, 32767);
        offer(make_particle(0, -32768 * 1024, 0, 32768 * 1024, 0, 0, 0, 0, 0));
        offer(make_particle(0, 32766 * 1024, 0, -32766 * 1024, 0, 0, 0, 0, 0));
        offer(make_particle(1, 32766 * 1024, 0, -32766 * 1024, -1024, 0, 0, 3, 9));

        // inverted and empty rectangles hide everything
        write_clip(100, 100, 50, 50);
        offer(make_particle(1, 75 * 1024, 0, -75 * 1024, 0, 0, 0, 2, 2));
        offer(mid_particle(0, 4, 4));
        write_clip(200, 150, 200, 150);
        offer(make_particle(1, 200 * 1024, 0, -150 * 1024, 0, 0, 0, 1, 1));
        offer(mid_particle(0, 4, 4));

        for (int phase = 0; phase < 6; phase++) begin
            l = $urandom_range(0, 400) - 200;
            t = $urandom_range(0, 400) - 200;
            case (phase)
                0: write_clip(-32768, -32768, 32767, 32767);
                3: write_clip(0, 0, 640, 480);
                5: write_clip($urandom, $urandom, $urandom, $urandom);
                default: write_clip(l, t, l + $urandom_range(1, 700), t + $urandom_range(1, 500));
            endcase
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 4) == 0)
                    offer(noise_particle());
                else
                    offer(aimed_particle());
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && points_due == 0)
            $display("PASS particle_trail_point_emitter");
        else
            $display("FAIL particle_trail_point_emitter");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL particle_trail_point_emitter");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ptpe_pkg.sv
rtl/core/ptpe_alu.sv
rtl/core/ptpe_clip.sv
rtl/core/particle_trail_point_emitter.sv
tb/sv/ptpe_checker.sv
tb/sv/tb_top.sv
